// File: sv/ccs_pkg.sv
package ccs_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_SERIES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_MAX_VOLTAGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_CHARGING = 3'd4;

    // register reset values
    localparam logic [11:0] RST_TASK_INTERVAL = 12'd500;
    localparam logic [11:0] RST_PRESENCE_TIMEOUT = 12'd2000;
    localparam logic [5:0] RST_CELLS_IN_SERIES = 6'd12;
    localparam logic [12:0] RST_CELL_MAX_VOLTAGE = 13'd4301;
    localparam logic RST_BALANCE_CHARGING = 1'b0;

    // input commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // frame kinds of a result
    localparam logic [1:0] KIND_BMS_HB = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_SETPOINT = 2'd2;

    // CAN identifiers
    localparam logic [10:0] ID_CHARGER_HB = 11'h70A;
    localparam logic [10:0] ID_BMS_HB = 11'h701;
    localparam logic [10:0] ID_START = 11'h000;
    localparam logic [10:0] ID_SETPOINT = 11'h40A;

    localparam logic [7:0] NODE_OPERATIONAL = 8'h05;
    localparam logic [11:0] AGE_MAX = 12'hFFF;

    // 0.6 V in 1/1024 V, truncated
    localparam logic [19:0] VOLT_OFFSET_Q10 = 20'd614;
    localparam logic [17:0] VOLT_MAX = 18'h3FFFF;
    localparam logic [9:0] THROTTLE_MAX = 10'd1000;
    // 30 A * duty / 1000 in 1/16 A = 12 * duty / 25, as 12 * 2^17 / 25 rounded up
    localparam logic [15:0] CUR_RECIP = 16'd62915;
    localparam int CUR_SHIFT = 17;

    typedef enum logic [3:0] {
        SEQ_INIT     = 4'b0001,
        SEQ_RESET    = 4'b0010,
        SEQ_SET      = 4'b0100,
        SEQ_CHARGING = 4'b1000
    } t_seq;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [10:0] tx_id;
        logic [8:0]  current_request;
        logic [17:0] voltage_request;
        logic        ready_flag;
        logic        balance_write;
        logic        balance_value;
        logic        last;
    } t_result;

endpackage

// File: sv/can_charger_supervisor.sv
// Channel | Direction | Handshake             | Payload
// input   | in        | i_valid / o_stall     | i_cmd, i_frame_id, i_first_byte,
//         |           |                       | i_power_down, i_charge_throttle
// result  | out       | o_valid / i_stall     | o_frame_kind, o_tx_id, o_current_request,
//         |           |                       | o_voltage_request, o_ready_flag,
//         |           |                       | o_balance_write, o_balance_value, o_last
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// An accepted transaction is held in the input register, then the supervision
// logic updates state and pushes zero, one or two results into a four-entry result queue.
// Results leave from the head of the queue; an item is taken every cycle while the
// queue has room for two results, so a tick that sends two frames leaves as two results.
// Reset (synchronous, active low) loads register defaults, sequence init, ages and counts 0.
// A stalled result queue fills and then raises o_stall; config writes are always taken.
module can_charger_supervisor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_cmd,
    input  logic [10:0]                   i_frame_id,
    input  logic [7:0]                    i_first_byte,
    input  logic                          i_power_down,
    input  logic [9:0]                    i_charge_throttle,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_frame_kind,
    output logic [10:0]                   o_tx_id,
    output logic [8:0]                    o_current_request,
    output logic [17:0]                   o_voltage_request,
    output logic                          o_ready_flag,
    output logic                          o_balance_write,
    output logic                          o_balance_value,
    output logic                          o_last,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ccs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ccs_pkg::*;

    // configuration registers
    logic [11:0] r_task_interval;
    logic [11:0] r_presence_timeout;
    logic [5:0]  r_cells;
    logic [12:0] r_cell_max;
    logic        r_balance;
    // voltage setpoint, refreshed every cycle from the configuration
    logic [17:0] r_volt;
    logic [19:0] volt_full;

    // input register
    logic        r_in_vld;
    logic        r_cmd;
    logic [10:0] r_frame_id;
    logic [7:0]  r_first_byte;
    logic        r_power_down;
    logic [9:0]  r_throttle;

    // supervision state
    t_seq        r_seq, n_seq;
    logic [7:0]  r_node, n_node;
    logic [11:0] r_age, n_age;
    logic [11:0] r_cnt, n_cnt;

    // result queue
    t_result     r_fifo [4];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_count;
    logic        room;
    logic        fire;
    logic        pop;
    logic        in_accept;
    logic [1:0]  n_push;
    t_result     res0, res1;
    t_result     head;

    // step-local terms
    logic [11:0] age_inc;
    logic [11:0] cnt_inc;
    logic        step;
    logic        present;
    logic [9:0]  thr_clamped;
    logic [25:0] cur_prod;
    logic [8:0]  cur_q4;

    assign o_cfg_ready = 1'b1;

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_interval    <= RST_TASK_INTERVAL;
            r_presence_timeout <= RST_PRESENCE_TIMEOUT;
            r_cells            <= RST_CELLS_IN_SERIES;
            r_cell_max         <= RST_CELL_MAX_VOLTAGE;
            r_balance          <= RST_BALANCE_CHARGING;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TASK_INTERVAL:    r_task_interval <= i_cfg_data[11:0];
                CFG_PRESENCE_TIMEOUT: r_presence_timeout <= i_cfg_data[11:0];
                CFG_CELLS_IN_SERIES:  r_cells <= i_cfg_data[5:0];
                CFG_CELL_MAX_VOLTAGE: r_cell_max <= i_cfg_data[12:0];
                CFG_BALANCE_CHARGING: r_balance <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // pack voltage = cells * cell limit + 0.6 V, saturate to the field range
    assign volt_full = 20'(r_cells * r_cell_max) + VOLT_OFFSET_Q10;

    always_ff @(posedge i_clk) begin
        if (volt_full > 20'(VOLT_MAX)) begin
            r_volt <= VOLT_MAX;
        end else begin
            r_volt <= volt_full[17:0];
        end
    end

    // queue handshake: accept a step only with room for two results
    assign room      = (r_count <= 3'd2);
    assign fire      = r_in_vld && room;
    assign o_stall   = r_in_vld && !room;
    assign in_accept = i_valid && !o_stall;
    assign pop       = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd        <= i_cmd;
            r_frame_id   <= i_frame_id;
            r_first_byte <= i_first_byte;
            r_power_down <= i_power_down;
            r_throttle   <= i_charge_throttle;
        end
    end

    // current = floor(12 * duty / 25) through a scaled reciprocal; exact for duty <= 1000
    assign thr_clamped = (r_throttle > THROTTLE_MAX) ? THROTTLE_MAX : r_throttle;
    assign cur_prod    = 26'(thr_clamped * CUR_RECIP);
    assign cur_q4      = cur_prod[CUR_SHIFT+8:CUR_SHIFT];

    assign age_inc = (r_age < AGE_MAX) ? r_age + 12'd1 : r_age;
    assign cnt_inc = r_cnt + 12'd1;
    assign step    = (cnt_inc >= r_task_interval);
    assign present = (age_inc < r_presence_timeout);

    // one supervision pass over the registered transaction
    always_comb begin
        n_seq  = r_seq;
        n_node = r_node;
        n_age  = r_age;
        n_cnt  = r_cnt;
        n_push = 2'd0;
        res0   = '0;
        res1   = '0;

        if (fire) begin
            if (r_cmd == CMD_FRAME) begin
                // charger heartbeat: restart the age, latch its network state
                if (r_frame_id == ID_CHARGER_HB) begin
                    n_age  = '0;
                    n_node = r_first_byte;
                end
            end else begin
                n_age = age_inc;
                n_cnt = step ? 12'd0 : cnt_inc;
                if (step && !present) begin
                    n_seq = SEQ_INIT;
                end else if (step) begin
                    res0.frame_kind = KIND_BMS_HB;
                    res0.tx_id      = ID_BMS_HB;
                    res1.frame_kind = KIND_SETPOINT;
                    res1.tx_id      = ID_SETPOINT;
                    res1.last       = 1'b1;
                    n_push          = 2'd2;
                    if (r_node != NODE_OPERATIONAL) begin
                        // not operational: ask the charger to start its node
                        res1.frame_kind = KIND_START;
                        res1.tx_id      = ID_START;
                    end else begin
                        res0.balance_write = 1'b1;
                        res0.balance_value = r_balance;
                        unique case (r_seq)
                            SEQ_INIT: begin
                                if (!r_power_down) begin
                                    n_seq     = SEQ_RESET;
                                    n_push    = 2'd1;
                                    res0.last = 1'b1;
                                end
                            end
                            SEQ_RESET: begin
                                n_seq = SEQ_SET;
                            end
                            SEQ_SET: begin
                                res1.ready_flag = 1'b1;
                                n_seq           = SEQ_CHARGING;
                            end
                            SEQ_CHARGING: begin
                                res1.ready_flag      = 1'b1;
                                res1.current_request = cur_q4;
                                res1.voltage_request = r_volt;
                                if (r_power_down) begin
                                    n_seq = SEQ_INIT;
                                end
                            end
                            default: begin
                                n_seq = SEQ_INIT;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= SEQ_INIT;
            r_node <= '0;
            r_age  <= '0;
            r_cnt  <= '0;
        end else begin
            r_seq  <= n_seq;
            r_node <= n_node;
            r_age  <= n_age;
            r_cnt  <= n_cnt;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wr] <= res0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wr + 2'd1] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + n_push;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= r_count + {1'b0, n_push} - {2'b00, pop};
        end
    end

    assign o_valid = (r_count != 3'd0);
    assign head    = r_fifo[r_rd];

    assign o_frame_kind      = head.frame_kind;
    assign o_tx_id           = head.tx_id;
    assign o_current_request = head.current_request;
    assign o_voltage_request = head.voltage_request;
    assign o_ready_flag      = head.ready_flag;
    assign o_balance_write   = head.balance_write;
    assign o_balance_value   = head.balance_value;
    assign o_last            = head.last;

endmodule
